// File: rtl/core/md5_pkg.sv
// MD5 package: sequencer states, initial chaining words and round tables.
package md5_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD2,
    ST_OUT
  } state_e;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic        OP_ABSORB = 1'b0;
  localparam logic        OP_FINISH = 1'b1;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] i);
    logic [4:0] s;
    unique case (i)
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/md5_message_digest.sv
// MD5 message digest: byte absorber with an iterative one-round-per-cycle compressor.
//
// Input channel: one item per transfer, opcode_i selects absorb (data_byte_i
// is packed little-endian into the 64-byte block) or finish. Output channel:
// one digest transfer per finish, four little-endian words.
// An absorb that does not complete a block leaves the input ready for the
// next byte. The 64th byte of a block starts the compressor: one round per
// cycle through a single shared adder/rotate round unit, then the chaining
// add, and the input waits until that add is done. A finish runs one
// compression, or two when 8 bytes or fewer of room remain, then holds the
// digest until it is taken.
// in_ready_o is low while compressing and while a digest waits; a stalled
// receiver therefore stalls the input side too.
// Reset (rst_ni low) restores the initial chaining words and a zero byte
// count; the message block needs no clearing since each word is rewritten
// from its first byte lane before use, and finish zeroes the tail.
// After a digest transfer the block is back at the initial state.
module md5_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_a_o,
  output logic [31:0] digest_word_b_o,
  output logic [31:0] digest_word_c_o,
  output logic [31:0] digest_word_d_o
);

  md5_pkg::state_e state_q, state_d;
  logic [31:0] blk_q [16];
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [63:0] cnt_q;
  logic [5:0]  rnd_q;
  logic        fin_q;   // compression belongs to a finish
  logic        pad2_q;  // a length-only block follows

  logic        acc;
  logic [5:0]  pos;
  assign acc = in_valid_i & in_ready_o;
  assign pos = cnt_q[5:0];

  // Round unit
  logic [1:0]  stage;
  logic [31:0] f;
  logic [3:0]  g;
  logic [31:0] sum, rot, newb;
  logic [4:0]  s;
  always_comb begin
    stage = rnd_q[5:4];
    unique case (stage)
      2'd0: begin f = d_q ^ (b_q & (c_q ^ d_q)); g = rnd_q[3:0]; end
      2'd1: begin
        f = c_q ^ (d_q & (b_q ^ c_q));
        g = 4'(({rnd_q[3:0], 2'b00}) + rnd_q[3:0] + 4'd1);
      end
      2'd2: begin
        f = b_q ^ c_q ^ d_q;
        g = 4'(({rnd_q[3:0], 1'b0}) + rnd_q[3:0] + 4'd5);
      end
      default: begin
        f = c_q ^ (b_q | ~d_q);
        g = 4'(({rnd_q[3:0], 3'b000}) - rnd_q[3:0]);
      end
    endcase
    sum = a_q + f + md5_pkg::round_const(rnd_q) + blk_q[g];
    s = md5_pkg::rot_amount({stage, rnd_q[1:0]});
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    newb = b_q + rot;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      md5_pkg::ST_IDLE:
        if (acc && (opcode_i == md5_pkg::OP_FINISH || pos == 6'd63))
          state_d = md5_pkg::ST_ROUND;
      md5_pkg::ST_ROUND: if (rnd_q == 6'd63) state_d = md5_pkg::ST_ADD;
      md5_pkg::ST_ADD:
        if (pad2_q) state_d = md5_pkg::ST_PAD2;
        else if (fin_q) state_d = md5_pkg::ST_OUT;
        else state_d = md5_pkg::ST_IDLE;
      md5_pkg::ST_PAD2: state_d = md5_pkg::ST_ROUND;
      md5_pkg::ST_OUT: if (out_ready_i) state_d = md5_pkg::ST_IDLE;
      default: state_d = md5_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = (state_q == md5_pkg::ST_IDLE);
    out_valid_o = (state_q == md5_pkg::ST_OUT);
  end
  assign digest_word_a_o = h_q[0];
  assign digest_word_b_o = h_q[1];
  assign digest_word_c_o = h_q[2];
  assign digest_word_d_o = h_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= md5_pkg::ST_IDLE;
      h_q[0] <= md5_pkg::IV_A;
      h_q[1] <= md5_pkg::IV_B;
      h_q[2] <= md5_pkg::IV_C;
      h_q[3] <= md5_pkg::IV_D;
      cnt_q <= '0;
      rnd_q <= '0;
      fin_q <= 1'b0;
      pad2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        md5_pkg::ST_IDLE:
          if (acc) begin
            rnd_q <= '0;
            if (opcode_i == md5_pkg::OP_FINISH) begin
              fin_q <= 1'b1;
              pad2_q <= (pos >= 6'd56);
            end else begin
              fin_q <= 1'b0;
              pad2_q <= 1'b0;
              cnt_q <= cnt_q + 64'd1;
            end
          end
        md5_pkg::ST_ROUND: rnd_q <= rnd_q + 6'd1;
        md5_pkg::ST_ADD: begin
          h_q[0] <= h_q[0] + a_q;
          h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q;
          pad2_q <= 1'b0;
        end
        md5_pkg::ST_PAD2: rnd_q <= '0;
        md5_pkg::ST_OUT:
          if (out_ready_i) begin
            h_q[0] <= md5_pkg::IV_A;
            h_q[1] <= md5_pkg::IV_B;
            h_q[2] <= md5_pkg::IV_C;
            h_q[3] <= md5_pkg::IV_D;
            cnt_q <= '0;
            fin_q <= 1'b0;
          end
        default: ;
      endcase
    end
  end

  // Working registers and message block
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      md5_pkg::ST_IDLE:
        if (acc) begin
          a_q <= h_q[0];
          b_q <= h_q[1];
          c_q <= h_q[2];
          d_q <= h_q[3];
          if (opcode_i == md5_pkg::OP_ABSORB) begin
            if (pos[1:0] == 2'd0) blk_q[pos[5:2]] <= {24'd0, data_byte_i};
            else blk_q[pos[5:2]][pos[1:0]*8 +: 8] <= data_byte_i;
          end else begin
            for (int w = 0; w < 16; w++) begin
              if (4'(w) == pos[5:2]) begin
                if (pos[1:0] == 2'd0) blk_q[w] <= {24'd0, md5_pkg::PAD_BYTE};
                else blk_q[w][pos[1:0]*8 +: 8] <= md5_pkg::PAD_BYTE;
              end else if (4'(w) > pos[5:2]) begin
                blk_q[w] <= '0;
              end
            end
            // length goes in now unless a second block carries it
            if (pos < 6'd56) begin
              blk_q[14] <= {cnt_q[28:0], 3'b000};
              blk_q[15] <= cnt_q[60:29];
            end
          end
        end
      md5_pkg::ST_ROUND: begin
        a_q <= d_q;
        b_q <= newb;
        c_q <= b_q;
        d_q <= c_q;
      end
      md5_pkg::ST_PAD2: begin
        a_q <= h_q[0];
        b_q <= h_q[1];
        c_q <= h_q[2];
        d_q <= h_q[3];
        for (int w = 0; w < 14; w++) blk_q[w] <= '0;
        blk_q[14] <= {cnt_q[28:0], 3'b000};
        blk_q[15] <= cnt_q[60:29];
      end
      default: ;
    endcase
  end

endmodule

// File: tb/md5_message_digest_test.sv
// Testbench for the MD5 byte-stream digest block: directed table, random messages, idle phases.
module md5_message_digest_test;

  typedef struct {
    logic       op;
    logic [7:0] data;
    logic       known;
    logic [31:0] wa, wb, wc, wd;
  } row_t;

  typedef struct {
    logic [31:0] a, b, c, d;
  } digest_t;

  localparam int unsigned KTAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int unsigned STAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                        6, 10, 15, 21};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic opcode_i = md5_pkg::OP_ABSORB;
  logic [7:0] data_byte_i = 8'h00;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o;
  logic [31:0] digest_word_a_o, digest_word_b_o, digest_word_c_o, digest_word_d_o;

  md5_message_digest dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [63:0] nbytes;
  digest_t digest_q[$];
  int errors = 0;
  int stall_pct = 0;
  int gap_pct = 0;
  int digests_seen = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %08h want %08h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void compress();
    logic [31:0] a, b, c, d, f, t;
    int g;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin f = d ^ (b & (c ^ d)); g = r; end
        1: begin f = c ^ (d & (b ^ c)); g = 5 * r + 1; end
        2: begin f = b ^ c ^ d; g = 3 * r + 5; end
        default: begin f = c ^ (b | ~d); g = 7 * r; end
      endcase
      g = g % 16;
      t = d; d = c; c = b;
      b = b + rotl(a + f + KTAB[r] + blk[g], STAB[(r / 16) * 4 + r % 4]);
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endfunction

  function automatic void restart();
    chain[0] = md5_pkg::IV_A; chain[1] = md5_pkg::IV_B;
    chain[2] = md5_pkg::IV_C; chain[3] = md5_pkg::IV_D;
    foreach (blk[i]) blk[i] = '0;
    nbytes = '0;
  endfunction

  function automatic void lane_write(input int pos, input logic [7:0] v);
    if (pos % 4 == 0) blk[pos / 4] = {24'h0, v};
    else blk[pos / 4][8 * (pos % 4) +: 8] = v;
  endfunction

  // advance the predictor by one accepted item; finish pushes a digest
  function automatic void md5_absorb_or_finish(input logic op, input logic [7:0] v);
    int pos;
    digest_t dg;
    logic [63:0] bits;
    pos = nbytes[5:0];
    if (op == md5_pkg::OP_ABSORB) begin
      lane_write(pos, v);
      nbytes++;
      if (pos == 63) compress();
      return;
    end
    lane_write(pos, md5_pkg::PAD_BYTE);
    for (int w = pos / 4 + 1; w < 16; w++) blk[w] = '0;
    if (pos >= 56) begin
      compress();
      foreach (blk[i]) blk[i] = '0;
    end
    bits = nbytes << 3;
    blk[14] = bits[31:0];
    blk[15] = bits[63:32];
    compress();
    dg.a = chain[0]; dg.b = chain[1]; dg.c = chain[2]; dg.d = chain[3];
    digest_q.push_back(dg);
    restart();
  endfunction

  // drop valid only while idling, so back-to-back transfers keep it high
  task automatic send(input logic op, input logic [7:0] v);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    data_byte_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    md5_absorb_or_finish(op, v);
    @(negedge clk_i);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send(md5_pkg::OP_ABSORB, 8'($urandom));
    send(md5_pkg::OP_FINISH, 8'($urandom));
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        report("unexpected digest", digest_word_a_o, '0);
      end else begin
        digest_t w;
        w = digest_q.pop_front();
        if (digest_word_a_o !== w.a) report("word a", digest_word_a_o, w.a);
        if (digest_word_b_o !== w.b) report("word b", digest_word_b_o, w.b);
        if (digest_word_c_o !== w.c) report("word c", digest_word_c_o, w.c);
        if (digest_word_d_o !== w.d) report("word d", digest_word_d_o, w.d);
      end
    end
  end

  row_t dir_rows [$];

  function automatic void add_row(input logic op, input logic [7:0] v);
    row_t r;
    r.op = op; r.data = v; r.known = 1'b0;
    r.wa = '0; r.wb = '0; r.wc = '0; r.wd = '0;
    dir_rows.push_back(r);
  endfunction

  initial begin
    row_t r;
    digest_t w;
    int lens [8] = '{55, 56, 57, 63, 64, 119, 120, 128};
    restart();
    // empty message: d41d8cd98f00b204e9800998ecf8427e
    r.op = md5_pkg::OP_FINISH; r.data = 8'hff; r.known = 1'b1;
    r.wa = 32'hd98c1dd4; r.wb = 32'h04b2008f; r.wc = 32'h980980e9; r.wd = 32'h7e42f8ec;
    dir_rows.push_back(r);
    // "a": 0cc175b9c0f1b6a831c399e269772661
    r.op = md5_pkg::OP_ABSORB; r.data = 8'h61; r.known = 1'b0;
    dir_rows.push_back(r);
    r.op = md5_pkg::OP_FINISH; r.data = 8'h00; r.known = 1'b1;
    r.wa = 32'hb975c10c; r.wb = 32'ha8b6f1c0; r.wc = 32'he299c331; r.wd = 32'h61267769;
    dir_rows.push_back(r);
    add_row(md5_pkg::OP_ABSORB, 8'h00);
    add_row(md5_pkg::OP_ABSORB, 8'hff);
    add_row(md5_pkg::OP_ABSORB, 8'h55);
    add_row(md5_pkg::OP_ABSORB, 8'haa);
    add_row(md5_pkg::OP_FINISH, 8'h5a);
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == md5_pkg::OP_FINISH && dir_rows[i].known) begin
        int n;
        n = digest_q.size();
        send(dir_rows[i].op, dir_rows[i].data);
        // the typed-in digest must agree with the predictor too
        w = digest_q[n];
        if (w.a !== dir_rows[i].wa) report("table a", w.a, dir_rows[i].wa);
        if (w.b !== dir_rows[i].wb) report("table b", w.b, dir_rows[i].wb);
        if (w.c !== dir_rows[i].wc) report("table c", w.c, dir_rows[i].wc);
        if (w.d !== dir_rows[i].wd) report("table d", w.d, dir_rows[i].wd);
      end else begin
        send(dir_rows[i].op, dir_rows[i].data);
      end
    end
    // padding boundaries: room left around 8 bytes, and exact block multiples
    foreach (lens[k]) send_message(lens[k]);
    for (int ph = 0; ph < 4; ph++) begin
      int budget;
      case (ph)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 54; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 54; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      budget = 290;
      while (budget > 0) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
        send_message(len);
        budget -= len + 1;
      end
      if ($urandom_range(1)) begin gap_pct = 0; stall_pct = 0; end
    end
    // leave a partial message behind: no digest expected from it
    repeat (3) send(md5_pkg::OP_ABSORB, 8'($urandom));
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// File: md5_message_digest.f
rtl/core/md5_pkg.sv
rtl/core/md5_message_digest.sv
tb/md5_message_digest_test.sv
